// ===== design/gtgps_pkg.sv =====
// shared types, constants and the arctangent table of the go-to-goal steering block
`default_nettype none

package gtgps_pkg;

   // cordic iteration count, default and table size
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   // datapath widths
   localparam int XY_W   = 36;  // cordic x/y, 17 bit differences scaled by 2^16 plus growth
   localparam int Z_W    = 34;  // angle accumulator, q2.30 plus headroom
   localparam int DIST_W = 17;  // rounded distance, q.10
   localparam int ERR_W  = 17;  // heading error, q5.12

   localparam logic signed [Z_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
   localparam logic [15:0]           INV_GAIN_Q16 = 16'd39797;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DIST    = 2'd2;

   localparam logic [15:0] LINEAR_GAIN_RST  = 16'd11469;
   localparam logic [15:0] ANGULAR_GAIN_RST = 16'd51472;
   localparam logic [14:0] STOP_DIST_RST    = 15'd307;

   typedef struct packed {
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] pose_heading;
      logic signed [15:0] goal_x;
      logic signed [15:0] goal_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] forward_speed;
      logic signed [15:0] turn_rate;
      logic               arrived;
   } rsp_type;

   // one word in flight through the cordic
   typedef struct packed {
      logic                   valid;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic signed [15:0]     hd;
   } vec_type;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [14:0] stop_distance;
   } cfg_type;

   // truncated atan(2^-i) in q2.30
   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      case (idx)
         0:       return 34'sd843314856;
         1:       return 34'sd497837829;
         2:       return 34'sd263043836;
         3:       return 34'sd133525158;
         4:       return 34'sd67021686;
         5:       return 34'sd33543515;
         6:       return 34'sd16775850;
         7:       return 34'sd8388437;
         8:       return 34'sd4194282;
         9:       return 34'sd2097149;
         10:      return 34'sd1048575;
         11:      return 34'sd524287;
         12:      return 34'sd262143;
         13:      return 34'sd131071;
         14:      return 34'sd65535;
         15:      return 34'sd32767;
         16:      return 34'sd16383;
         17:      return 34'sd8191;
         18:      return 34'sd4095;
         19:      return 34'sd2047;
         20:      return 34'sd1023;
         21:      return 34'sd511;
         22:      return 34'sd255;
         23:      return 34'sd127;
         default: return '0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== design/gtgps_prerot.sv =====
// entry stage: position differences and rotation into the right half-plane
`default_nettype none

module gtgps_prerot (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    enable,
   input  wire                    in_valid,
   input  gtgps_pkg::req_type     in_data,
   output gtgps_pkg::vec_type     out_vec
);
   import gtgps_pkg::*;

   vec_type vec_ff, vec_in;
   logic signed [16:0] dx, dy, x17, y17;

   always_comb begin
      dx = {in_data.goal_x[15], in_data.goal_x} - {in_data.pose_x[15], in_data.pose_x};
      dy = {in_data.goal_y[15], in_data.goal_y} - {in_data.pose_y[15], in_data.pose_y};
      vec_in = '0;
      vec_in.valid = in_valid;
      vec_in.hd    = in_data.pose_heading;
      if (dx[16]) begin
         if (!dy[16]) begin
            x17      = dy;
            y17      = -dx;
            vec_in.z = HALF_PI_Q30;
         end else begin
            x17      = -dy;
            y17      = dx;
            vec_in.z = -HALF_PI_Q30;
         end
      end else begin
         x17      = dx;
         y17      = dy;
         vec_in.z = '0;
      end
      // scale by 2^16 on entry
      vec_in.x = {{(XY_W-33){x17[16]}}, x17, 16'b0};
      vec_in.y = {{(XY_W-33){y17[16]}}, y17, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign out_vec = vec_ff;

endmodule

`default_nettype wire

// ===== design/gtgps_cordic_stage.sv =====
// one registered cordic vectoring iteration
`default_nettype none

module gtgps_cordic_stage #(
   parameter int STAGE = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    enable,
   input  gtgps_pkg::vec_type     in_vec,
   output gtgps_pkg::vec_type     out_vec
);
   import gtgps_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN_C = atan_q30(STAGE);

   vec_type vec_ff, vec_in;
   logic signed [XY_W-1:0] xs, ys;

   always_comb begin
      xs = in_vec.x >>> STAGE;
      ys = in_vec.y >>> STAGE;
      vec_in = in_vec;
      if (!in_vec.y[XY_W-1]) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + ATAN_C;
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - ATAN_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign out_vec = vec_ff;

endmodule

`default_nettype wire

// ===== design/gtgps_post.sv =====
// gain correction, heading error, arrival test, speed products and saturation
`default_nettype none

module gtgps_post (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    enable,
   input  gtgps_pkg::vec_type     in_vec,
   input  gtgps_pkg::cfg_type     cfg,
   output logic                   out_valid,
   output gtgps_pkg::rsp_type     out_data
);
   import gtgps_pkg::*;

   localparam int PROD_W = XY_W - 1 + 16;

   // stage a: distance product and heading error
   logic                    a_valid_ff;
   logic [PROD_W-1:0]       a_prod_ff, a_prod_in;
   logic signed [ERR_W-1:0] a_err_ff, a_err_in;
   logic signed [Z_W-1:0]   zsum;
   logic signed [15:0]      bearing;

   always_comb begin
      a_prod_in = in_vec.x[XY_W-2:0] * INV_GAIN_Q16;
      zsum      = in_vec.z + Z_W'(1 <<< 17);
      bearing   = zsum[Z_W-1:18];
      a_err_in  = {bearing[15], bearing} - {in_vec.hd[15], in_vec.hd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_vec.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_prod_ff <= a_prod_in;
         a_err_ff  <= a_err_in;
      end
   end

   // stage b: rounded distance, arrival test, gain products
   logic                    b_valid_ff;
   logic                    b_arrived_ff, b_arrived_in;
   logic [DIST_W+15:0]      b_fprod_ff, b_fprod_in;
   logic signed [ERR_W+16:0] b_tprod_ff, b_tprod_in;
   logic [PROD_W-1:0]       dsum;
   logic [DIST_W-1:0]       dist_q10;

   always_comb begin
      dsum         = a_prod_ff + PROD_W'(64'd1 << 31);
      dist_q10     = dsum[32+DIST_W-1:32];
      b_arrived_in = (dist_q10 <= {{(DIST_W-15){1'b0}}, cfg.stop_distance});
      b_fprod_in   = cfg.linear_gain * dist_q10;
      b_tprod_in   = $signed({1'b0, cfg.angular_gain}) * a_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_arrived_ff <= b_arrived_in;
         b_fprod_ff   <= b_fprod_in;
         b_tprod_ff   <= b_tprod_in;
      end
   end

   // stage c: round, saturate, zero on arrival
   logic                     c_valid_ff;
   rsp_type                  c_data_ff, c_data_in;
   logic [DIST_W+16:0]       fsum;
   logic [DIST_W+2:0]        fq;
   logic signed [ERR_W+17:0] tsum;
   logic signed [ERR_W+1:0]  tq;

   always_comb begin
      fsum = {1'b0, b_fprod_ff} + (DIST_W+17)'(1 << 13);
      fq   = fsum[DIST_W+16:14];
      tsum = {b_tprod_ff[ERR_W+16], b_tprod_ff} + (ERR_W+18)'(1 << 15);
      tq   = tsum[ERR_W+17:16];
      c_data_in = '0;
      if (b_arrived_ff) begin
         c_data_in.arrived = 1'b1;
      end else begin
         if (fq > (DIST_W+3)'(32767)) begin
            c_data_in.forward_speed = 16'sh7FFF;
         end else begin
            c_data_in.forward_speed = fq[15:0];
         end
         if (tq > (ERR_W+2)'(32767)) begin
            c_data_in.turn_rate = 16'sh7FFF;
         end else if (tq < -(ERR_W+2)'(32768)) begin
            c_data_in.turn_rate = 16'sh8000;
         end else begin
            c_data_in.turn_rate = tq[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (enable) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

`default_nettype wire

// ===== design/go_to_goal_proportional_steer_top.sv =====
// top level of the go-to-goal proportional steering pipeline
//
// usage
//   req channel: one word carries the pose (x, y, heading) and the goal point;
//   taken when req_valid and req_ready are both high
//   rsp channel: one word per request, forward speed, turn rate and the arrived
//   flag, in request order; taken when rsp_valid and rsp_ready are both high
//   csr port: csr_we writes csr_wdata to the register at csr_index
//   (0 linear gain, 1 angular gain, 2 stop distance, index 3 ignored);
//   write only while no word is in flight
// timing
//   latency is CORDIC_STEPS + 4 cycles from request to response (20 by default):
//   one entry stage, one stage per cordic iteration, three output stages
//   throughput is one word per cycle, set by the fully unrolled cordic
// reset
//   synchronous reset empties the pipeline and loads the default gains
//   (0.7, pi) and stop distance (0.3)
// stall
//   while rsp_valid is high and rsp_ready low, the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated
`default_nettype none

module go_to_goal_proportional_steer_top #(
   parameter int CORDIC_STEPS = gtgps_pkg::CORDIC_STEPS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  gtgps_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output gtgps_pkg::rsp_type                   rsp_data,
   input  wire                                  csr_we,
   input  wire  [gtgps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [15:0]                          csr_wdata
);
   import gtgps_pkg::*;

   // the whole pipeline moves together unless the output word is stuck
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain   <= LINEAR_GAIN_RST;
         cfg_ff.angular_gain  <= ANGULAR_GAIN_RST;
         cfg_ff.stop_distance <= STOP_DIST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINEAR_GAIN:  cfg_ff.linear_gain   <= csr_wdata;
            CSR_ANGULAR_GAIN: cfg_ff.angular_gain  <= csr_wdata;
            CSR_STOP_DIST:    cfg_ff.stop_distance <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // cordic chain: entry stage feeds element 0
   vec_type chain [CORDIC_STEPS+1];

   gtgps_prerot u_prerot (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_vec  (chain[0])
   );

   // one iteration per stage, atan constants fixed at elaboration
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      gtgps_cordic_stage #(
         .STAGE (g)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .in_vec  (chain[g]),
         .out_vec (chain[g+1])
      );
   end

   // distance scaling, heading error, gains and saturation
   gtgps_post u_post (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_vec    (chain[CORDIC_STEPS]),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire
